[rtl/psh_pkg.sv]
// Package for the pair sum hash matcher.
// Holds the controller state type and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psh_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/psh_if.sv]
// Channel interfaces for the pair sum hash matcher.
// Input item channel and result channel, valid/ready handshake.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psh_in_if;
  logic                            valid;
  logic                            ready;
  logic [psh_pkg::VALUE_W-1:0]     item_value;
  logic                            last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface psh_out_if;
  logic                            valid;
  logic                            ready;
  logic                            pair_found;
  logic [psh_pkg::VALUE_W-1:0]     partner_value;
  logic                            none_in_set;
  logic                            table_full;
  logic                            set_done;

  modport source (output valid, output pair_found, output partner_value,
                  output none_in_set, output table_full, output set_done,
                  input ready);
  modport sink   (input valid, input pair_found, input partner_value,
                  input none_in_set, input table_full, input set_done,
                  output ready);
endinterface

`default_nettype wire

[rtl/psh_ctrl.sv]
// Controller for the pair sum hash matcher.
// Sequences load, table scan and result hand-off; drives the input ready.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire psh_pkg::dp_status_t status,
  output psh_pkg::dp_cmd_t        cmd
);

  psh_pkg::ctrl_state_t state;
  psh_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      psh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = psh_pkg::S_SCAN;
        end
      end
      psh_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = psh_pkg::S_FINISH;
        end
      end
      psh_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = psh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psh_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/psh_datapath.sv]
// Datapath for the pair sum hash matcher.
// Value table, fill count, complement, scan compare and result register.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psh_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [psh_pkg::VALUE_W-1:0] cfg_wr_data,
  input  wire logic [psh_pkg::VALUE_W-1:0] item_value,
  input  wire logic                        last_item,
  input  wire psh_pkg::dp_cmd_t            cmd,
  output psh_pkg::dp_status_t              status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             pair_found,
  output logic [psh_pkg::VALUE_W-1:0]      partner_value,
  output logic                             none_in_set,
  output logic                             table_full,
  output logic                             set_done
);

  localparam int unsigned VW    = psh_pkg::VALUE_W;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_ENTRIES);

  logic [VW-1:0]    mem [TABLE_ENTRIES];
  logic [VW-1:0]    target_sum;
  logic [VW-1:0]    val_q;
  logic             last_q;
  logic [VW:0]      comp_q;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;
  logic             any_pair_seen;
  logic             any_next;
  logic [CNT_W-1:0] idx;
  logic [VW-1:0]    rd_data;
  logic             rd_vld;
  logic             hit_q;
  logic             dup_q;
  logic             rd_en;
  logic             comp_ok;
  logic             miss_new;
  logic             do_store;
  logic [VW:0]      comp_calc;

  assign comp_calc = {target_sum[VW-1], target_sum} - {item_value[VW-1], item_value};
  assign comp_ok   = (comp_q[VW] == comp_q[VW-1]);
  assign rd_en     = cmd.scan && (idx != fill_count);
  assign miss_new  = !hit_q && !dup_q;
  assign do_store  = miss_new && (fill_count < CAPACITY);
  assign any_next  = any_pair_seen | hit_q;
  assign fill_next = last_q ? '0 : fill_count + CNT_W'(do_store);

  assign status.scan_done = (idx == fill_count) && !rd_vld;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_wr_en) begin
      target_sum <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
    if (cmd.finish && do_store) begin
      mem[fill_count[IDX_W-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_q  <= item_value;
      last_q <= last_item;
      comp_q <= comp_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      hit_q  <= 1'b0;
      dup_q  <= 1'b0;
    end else if (cmd.load) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      hit_q  <= 1'b0;
      dup_q  <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        idx <= idx + CNT_W'(1);
      end
      if (rd_vld) begin
        if (comp_ok && (rd_data == comp_q[VW-1:0])) begin
          hit_q <= 1'b1;
        end
        if (rd_data == val_q) begin
          dup_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      any_pair_seen <= 1'b0;
    end else if (cmd.finish) begin
      fill_count    <= fill_next;
      any_pair_seen <= last_q ? 1'b0 : any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pair_found    <= hit_q;
      partner_value <= hit_q ? comp_q[VW-1:0] : '0;
      none_in_set   <= last_q && !any_next;
      table_full    <= miss_new && (fill_count >= CAPACITY);
      set_done      <= last_q;
    end
  end

endmodule

`default_nettype wire

[rtl/pair_sum_hash_matcher.sv]
// Top level of the pair sum hash matcher.
// Joins psh_ctrl and psh_datapath to the item and result channels.
// Depends on psh_pkg, psh_in_if, psh_out_if, psh_ctrl, psh_datapath.
//
//   channel     dir   handshake      payload
//   item_in     in    valid/ready    item_value[31:0], last_item
//   result_out  out   valid/ready    pair_found, partner_value[31:0], none_in_set,
//                                    table_full, set_done
//   cfg         in    cfg_wr_en      cfg_wr_data[31:0] (target_sum)
//
// One item at a time: each item is loaded, checked by a linear scan of the value table
// through its single registered read port, and finished into the result register.
// The result register frees the input side: a new item is taken while a result waits.
// A stalled result holds the finishing step, and with it the next item's result.
// Reset (rst, synchronous) empties the table at once through the fill count.
`timescale 1ns / 1ps
`default_nettype none

module pair_sum_hash_matcher #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [psh_pkg::VALUE_W-1:0] cfg_wr_data,
  psh_in_if.sink                           item_in,
  psh_out_if.source                        result_out
);

  psh_pkg::dp_cmd_t    cmd;
  psh_pkg::dp_status_t status;
  logic                in_ready;

  assign item_in.ready = in_ready;

  psh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  psh_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item_value    (item_in.item_value),
    .last_item     (item_in.last_item),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .pair_found    (result_out.pair_found),
    .partner_value (result_out.partner_value),
    .none_in_set   (result_out.none_in_set),
    .table_full    (result_out.table_full),
    .set_done      (result_out.set_done)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.finish}))
    else $error("more than one datapath command at once");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("item accepted while another is in work");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_out.valid)
    else $error("finished item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!$past(result_out.valid) || !result_out.valid || result_out.ready))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
